FILE: hdl/ghbp_pkg.sv
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared types and constants for the global history branch predictor.
// ----------------------------------------------------------------------------
package ghbp_pkg;

    localparam int HIST_LEN_DEF = 14;
    localparam int CTR_BITS_DEF = 4;

    localparam int THRESH_W = 4;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd2;

    localparam int CVAL_W = 4;
    localparam int CMP_W  = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } state_t;

endpackage

FILE: hdl/global_history_branch_predictor_top.sv
// ----------------------------------------------------------------------------
// global_history_branch_predictor_top
// Global history two-level predictor: one history register selects a
// saturating counter in a table with one read and one write port; predict reads, update
// reads, adjusts and writes back, then shifts the history.
// ----------------------------------------------------------------------------
// Flow: an accepted request moves to ST_CALC, where the counter read from the
// table is compared and adjusted and the result registers are loaded. A new
// request is taken only back in ST_IDLE and while the result register is free.
// Reset: the history and threshold reset at once; the counter table is then
// cleared one entry a cycle, all 2**HIST_LEN entries (16384 by default), during
// which in_ready stays low. Configuration writes are taken throughout.
module global_history_branch_predictor_top #(
    parameter int HIST_LEN = ghbp_pkg::HIST_LEN_DEF,
    parameter int CTR_BITS = ghbp_pkg::CTR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic                          outcome,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          predict_taken,
    output logic [ghbp_pkg::CVAL_W-1:0]   counter_value,
    input  logic                          cfg_we,
    input  logic [ghbp_pkg::THRESH_W-1:0] cfg_wdata
);

    localparam int DEPTH = 1 << HIST_LEN;
    localparam logic [CTR_BITS-1:0] CTR_MAX = '1;

    logic [CTR_BITS-1:0] table_mem [DEPTH];

    ghbp_pkg::state_t state_reg, state_next;

    logic [HIST_LEN-1:0]           hist_reg, hist_next;
    logic [HIST_LEN-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [ghbp_pkg::THRESH_W-1:0] thresh_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          func_reg;
    logic                          outcome_reg;
    logic                          pred_reg;
    logic [ghbp_pkg::CVAL_W-1:0]   cval_reg;
    logic [CTR_BITS-1:0]           rd_data_reg;

    logic                  accept;
    logic                  calc_pred;
    logic [CTR_BITS-1:0]   ctr_new;
    logic                  mem_we;
    logic [HIST_LEN-1:0]   mem_waddr;
    logic [CTR_BITS-1:0]   mem_wdata;

    assign in_ready      = (state_reg == ghbp_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign predict_taken = pred_reg;
    assign counter_value = cval_reg;

    assign calc_pred = ghbp_pkg::CMP_W'(rd_data_reg) >= ghbp_pkg::CMP_W'(thresh_reg);

    always_comb
    begin
        ctr_new = rd_data_reg;
        if (func_reg)
        begin
            if (outcome_reg && rd_data_reg != CTR_MAX)
            begin
                ctr_new = rd_data_reg + CTR_BITS'(1);
            end
            else if (!outcome_reg && rd_data_reg != '0)
            begin
                ctr_new = rd_data_reg - CTR_BITS'(1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hist_next      = hist_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = hist_reg;
        mem_wdata      = ctr_new;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ghbp_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + HIST_LEN'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ghbp_pkg::ST_IDLE;
                end
            end
            ghbp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ghbp_pkg::ST_CALC;
                end
            end
            ghbp_pkg::ST_CALC:
            begin
                mem_we         = func_reg;
                out_valid_next = 1'b1;
                if (func_reg)
                begin
                    hist_next = {outcome_reg, hist_reg[HIST_LEN-1:1]};
                end
                state_next = ghbp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ghbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ghbp_pkg::ST_CLEAR;
            hist_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= ghbp_pkg::THRESH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    // Hold request fields and load the result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            outcome_reg <= outcome;
        end
        if (state_reg == ghbp_pkg::ST_CALC)
        begin
            pred_reg <= calc_pred;
            cval_reg <= ghbp_pkg::CVAL_W'(ghbp_pkg::CMP_W'(ctr_new));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[hist_reg];
    end

endmodule

FILE: hdl/ghbp_checker.sv
// ----------------------------------------------------------------------------
// ghbp_checker
// Port-level checks for the global history branch predictor.
// ----------------------------------------------------------------------------
module ghbp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        predict_taken,
    input logic [ghbp_pkg::CVAL_W-1:0] counter_value
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(counter_value) && $stable(predict_taken))
        else $error("stalled result changed");

    // Block a new request while one is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken during processing");

    // Check that out_valid rises for each accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("result missing after request");

    // Never accept while an untaken result would be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("ready with blocked result register");

endmodule

bind global_history_branch_predictor_top ghbp_checker u_ghbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .predict_taken (predict_taken),
    .counter_value (counter_value)
);
